[design/itrd_pkg.sv]
`default_nettype none
package itrd_pkg;

  // Field and table geometry
  localparam int MAG_W          = 32;
  localparam int DIV_CNT_W      = 5;
  localparam int SYM_W          = 7;
  localparam int RADIX_W        = 6;
  localparam int SYM_REGS       = 7;
  localparam int SYM_REG_W      = 63;
  localparam int TBL_W          = SYM_REGS * SYM_REG_W;
  localparam int CFG_IDX_W      = 3;
  localparam int SEEN_W         = 2 ** SYM_W;
  localparam int MAX_SYMBOLS    = 63;
  localparam int MAX_DIGITS_DEF = 32;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_BASE_LENGTH   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SYMBOLS_FIRST = 3'd1;

  // ASCII codes
  localparam logic [SYM_W-1:0] CH_0     = 7'h30;
  localparam logic [SYM_W-1:0] CH_9     = 7'h39;
  localparam logic [SYM_W-1:0] CH_LA    = 7'h61;
  localparam logic [SYM_W-1:0] CH_LZ    = 7'h7a;
  localparam logic [SYM_W-1:0] CH_UA    = 7'h41;
  localparam logic [SYM_W-1:0] CH_UZ    = 7'h5a;
  localparam logic [SYM_W-1:0] CH_MINUS = 7'h2d;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CHECK,
    S_BAD,
    S_NEXT,
    S_DIV,
    S_WRD,
    S_SIGN,
    S_EMIT
  } state_t;

  // Controller to datapath
  typedef struct packed {
    logic load;
    logic chk_step;
    logic div_clr;
    logic div_step;
    logic wr_zero;
    logic wr_digit;
    logic rd_first;
    logic rd_next;
    logic emit_bad;
    logic emit_sign;
    logic emit_digit;
  } dp_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic len_bad;
    logic sym_bad;
    logic chk_last;
    logic mag_zero;
    logic cnt_zero;
    logic cnt_full;
    logic div_last;
    logic neg;
    logic ptr_zero;
  } dp_stat_t;

  function automatic logic is_alnum(input logic [SYM_W-1:0] c);
    return ((c >= CH_0) && (c <= CH_9)) || ((c >= CH_LA) && (c <= CH_LZ)) ||
           ((c >= CH_UA) && (c <= CH_UZ));
  endfunction

  // Symbol k sits at bits SYM_W*k of the flat table; the index past the table reads zero
  function automatic logic [SYM_W-1:0] sym_sel(input logic [TBL_W-1:0] tbl,
                                               input logic [RADIX_W-1:0] idx);
    logic [SYM_W-1:0] s;
    if (&idx) begin
      s = '0;
    end else begin
      s = tbl[SYM_W*idx +: SYM_W];
    end
    return s;
  endfunction

endpackage
`default_nettype wire

[design/integer_to_radix_digits.sv]
// Throughput: one number at a time; busy stays high until the last symbol is issued. Each
// digit takes a decide step, a 1-bit-per-cycle restoring division and a store step.
// Results come one per cycle after conversion and cannot be stalled.
// Reset (rst_n low, synchronous) clears the state machine and all configuration registers.
`default_nettype none
module integer_to_radix_digits
  import itrd_pkg::*;
#(
  parameter int MAX_DIGITS = MAX_DIGITS_DEF
) (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire logic                    start,
  output logic                         busy,
  input  wire logic signed [MAG_W-1:0] in_number,
  output logic                         out_valid,
  output logic [SYM_W-1:0]             out_symbol,
  output logic                         out_last,
  output logic                         out_base_invalid,
  input  wire logic                    cfg_we,
  input  wire logic [CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [SYM_REG_W-1:0]    cfg_data
);

  dp_cmd_t  cmd;
  dp_stat_t stat;

  // Sequencer
  itrd_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .stat  (stat),
    .cmd   (cmd)
  );

  // Check, divide, store and emit
  itrd_dp #(
    .MAX_DIGITS (MAX_DIGITS)
  ) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .in_number        (in_number),
    .cmd              (cmd),
    .stat             (stat),
    .out_valid        (out_valid),
    .out_symbol       (out_symbol),
    .out_last         (out_last),
    .out_base_invalid (out_base_invalid)
  );

endmodule
`default_nettype wire

[design/itrd_ram.sv]
`default_nettype none
module itrd_ram #(
  parameter int WIDTH = 7,
  parameter int DEPTH = 32
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // One write port, one registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule
`default_nettype wire

[design/itrd_ctrl.sv]
`default_nettype none
module itrd_ctrl
  import itrd_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     start,
  output logic          busy,
  input  wire dp_stat_t stat,
  output dp_cmd_t       cmd
);

  state_t state_r, state_nxt;

  // State register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state and commands
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      S_IDLE: begin
        if (start) begin
          cmd.load  = 1'b1;
          state_nxt = S_CHECK;
        end
      end
      // one symbol of the table per cycle
      S_CHECK: begin
        if (stat.len_bad || stat.sym_bad) begin
          state_nxt = S_BAD;
        end else begin
          cmd.chk_step = 1'b1;
          if (stat.chk_last) begin
            state_nxt = S_NEXT;
          end
        end
      end
      S_BAD: begin
        cmd.emit_bad = 1'b1;
        state_nxt    = S_IDLE;
      end
      // decide: zero value, done, or one more digit
      S_NEXT: begin
        if (stat.mag_zero && stat.cnt_zero) begin
          cmd.wr_zero = 1'b1;
          state_nxt   = S_SIGN;
        end else if (stat.mag_zero || stat.cnt_full) begin
          state_nxt = S_SIGN;
        end else begin
          cmd.div_clr = 1'b1;
          state_nxt   = S_DIV;
        end
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (stat.div_last) begin
          state_nxt = S_WRD;
        end
      end
      S_WRD: begin
        cmd.wr_digit = 1'b1;
        state_nxt    = S_NEXT;
      end
      // sign goes out while the top digit is read
      S_SIGN: begin
        cmd.rd_first  = 1'b1;
        cmd.emit_sign = stat.neg;
        state_nxt     = S_EMIT;
      end
      S_EMIT: begin
        cmd.emit_digit = 1'b1;
        if (stat.ptr_zero) begin
          state_nxt = S_IDLE;
        end else begin
          cmd.rd_next = 1'b1;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  assign busy = (state_r != S_IDLE);

  a_start_to_check: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> (state_r == S_CHECK))
    else $error("accepted transaction did not enter the base check");

  a_div_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DIV && !stat.div_last) |=> (state_r == S_DIV))
    else $error("division left before its last step");

  a_one_action: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({cmd.emit_bad, cmd.emit_sign, cmd.emit_digit, cmd.wr_zero, cmd.wr_digit}))
    else $error("store write and emission collide");

endmodule
`default_nettype wire

[design/itrd_dp.sv]
`default_nettype none
module itrd_dp
  import itrd_pkg::*;
#(
  parameter int MAX_DIGITS = MAX_DIGITS_DEF
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        cfg_we,
  input  wire logic [CFG_IDX_W-1:0]        cfg_index,
  input  wire logic [SYM_REG_W-1:0]        cfg_data,
  input  wire logic signed [MAG_W-1:0]     in_number,
  input  wire dp_cmd_t                     cmd,
  output dp_stat_t                         stat,
  output logic                             out_valid,
  output logic [SYM_W-1:0]                 out_symbol,
  output logic                             out_last,
  output logic                             out_base_invalid
);

  localparam int AW    = $clog2(MAX_DIGITS);
  localparam int CNT_W = $clog2(MAX_DIGITS + 1);

  // Configuration registers
  logic [RADIX_W-1:0]   base_len_r;
  logic [SYM_REG_W-1:0] sym_r [SYM_REGS];
  logic [TBL_W-1:0]     tbl;

  // Working registers
  logic                 neg_r, neg_nxt;
  logic [MAG_W-1:0]     q_r, q_nxt;
  logic [RADIX_W-1:0]   rem_r, rem_nxt;
  logic [DIV_CNT_W-1:0] div_cnt_r, div_cnt_nxt;
  logic [RADIX_W-1:0]   chk_idx_r, chk_idx_nxt;
  logic [SEEN_W-1:0]    seen_r, seen_nxt;
  logic [CNT_W-1:0]     cnt_r, cnt_nxt;
  logic [AW-1:0]        ptr_r, ptr_nxt;
  logic                 out_valid_r, out_valid_nxt;
  logic [SYM_W-1:0]     out_symbol_r, out_symbol_nxt;
  logic                 out_last_r, out_last_nxt;
  logic                 out_inv_r, out_inv_nxt;

  logic [SYM_W-1:0]     chk_sym;
  logic [RADIX_W:0]     rem_sh;
  logic                 rem_ge;
  logic [CNT_W-1:0]     cnt_dec;
  logic                 ram_we;
  logic [AW-1:0]        ram_waddr;
  logic [SYM_W-1:0]     ram_wdata;
  logic                 ram_re;
  logic [AW-1:0]        ram_raddr;
  logic [SYM_W-1:0]     ram_rdata;

  // Configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_len_r <= '0;
      for (int r = 0; r < SYM_REGS; r++) begin
        sym_r[r] <= '0;
      end
    end else if (cfg_we) begin
      if (cfg_index == REG_BASE_LENGTH) begin
        base_len_r <= cfg_data[RADIX_W-1:0];
      end else begin
        sym_r[cfg_index - REG_SYMBOLS_FIRST] <= cfg_data;
      end
    end
  end

  // Flat symbol table
  always_comb begin
    for (int r = 0; r < SYM_REGS; r++) begin
      tbl[r*SYM_REG_W +: SYM_REG_W] = sym_r[r];
    end
  end

  // Base check, one symbol per step against the seen mask
  assign chk_sym       = sym_sel(tbl, chk_idx_r);
  assign stat.len_bad  = (base_len_r < RADIX_W'(2)) ||
                         ({1'b0, base_len_r} > (RADIX_W + 1)'(MAX_SYMBOLS));
  assign stat.sym_bad  = !is_alnum(chk_sym) || seen_r[chk_sym];
  assign stat.chk_last = (chk_idx_r == base_len_r - RADIX_W'(1));

  // Restoring divide step, one quotient bit per cycle
  assign rem_sh = {rem_r, q_r[MAG_W-1]};
  assign rem_ge = (rem_sh >= {1'b0, base_len_r});

  assign cnt_dec = cnt_r - CNT_W'(1);

  assign stat.mag_zero = (q_r == '0);
  assign stat.cnt_zero = (cnt_r == '0);
  assign stat.cnt_full = (cnt_r == CNT_W'(MAX_DIGITS));
  assign stat.div_last = (&div_cnt_r);
  assign stat.neg      = neg_r;
  assign stat.ptr_zero = (ptr_r == '0);

  // Next-state logic for the working registers
  always_comb begin
    neg_nxt        = neg_r;
    q_nxt          = q_r;
    rem_nxt        = rem_r;
    div_cnt_nxt    = div_cnt_r;
    chk_idx_nxt    = chk_idx_r;
    seen_nxt       = seen_r;
    cnt_nxt        = cnt_r;
    ptr_nxt        = ptr_r;
    out_valid_nxt  = 1'b0;
    out_symbol_nxt = out_symbol_r;
    out_last_nxt   = out_last_r;
    out_inv_nxt    = out_inv_r;

    if (cmd.load) begin
      neg_nxt     = in_number[MAG_W-1];
      q_nxt       = in_number[MAG_W-1] ? (MAG_W'(0) - unsigned'(in_number))
                                       : unsigned'(in_number);
      cnt_nxt     = '0;
      chk_idx_nxt = '0;
      seen_nxt    = '0;
    end
    if (cmd.chk_step) begin
      seen_nxt[chk_sym] = 1'b1;
      chk_idx_nxt       = chk_idx_r + RADIX_W'(1);
    end
    if (cmd.div_clr) begin
      rem_nxt     = '0;
      div_cnt_nxt = '0;
    end
    if (cmd.div_step) begin
      rem_nxt     = rem_ge ? RADIX_W'(rem_sh - {1'b0, base_len_r}) : rem_sh[RADIX_W-1:0];
      q_nxt       = {q_r[MAG_W-2:0], rem_ge};
      div_cnt_nxt = div_cnt_r + DIV_CNT_W'(1);
    end
    if (cmd.wr_zero || cmd.wr_digit) begin
      cnt_nxt = cnt_r + CNT_W'(1);
    end
    if (cmd.rd_first) begin
      ptr_nxt = cnt_dec[AW-1:0];
    end
    if (cmd.rd_next) begin
      ptr_nxt = ptr_r - AW'(1);
    end

    // result register
    if (cmd.emit_bad) begin
      out_valid_nxt  = 1'b1;
      out_symbol_nxt = '0;
      out_last_nxt   = 1'b1;
      out_inv_nxt    = 1'b1;
    end else if (cmd.emit_sign) begin
      out_valid_nxt  = 1'b1;
      out_symbol_nxt = CH_MINUS;
      out_last_nxt   = 1'b0;
      out_inv_nxt    = 1'b0;
    end else if (cmd.emit_digit) begin
      out_valid_nxt  = 1'b1;
      out_symbol_nxt = ram_rdata;
      out_last_nxt   = (ptr_r == '0);
      out_inv_nxt    = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      neg_r       <= 1'b0;
      q_r         <= '0;
      cnt_r       <= '0;
    end else begin
      out_valid_r <= out_valid_nxt;
      neg_r       <= neg_nxt;
      q_r         <= q_nxt;
      cnt_r       <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r        <= rem_nxt;
    div_cnt_r    <= div_cnt_nxt;
    chk_idx_r    <= chk_idx_nxt;
    seen_r       <= seen_nxt;
    ptr_r        <= ptr_nxt;
    out_symbol_r <= out_symbol_nxt;
    out_last_r   <= out_last_nxt;
    out_inv_r    <= out_inv_nxt;
  end

  // Digit store, least significant digit at address zero
  assign ram_we    = cmd.wr_zero || cmd.wr_digit;
  assign ram_waddr = cmd.wr_zero ? '0 : cnt_r[AW-1:0];
  assign ram_wdata = sym_sel(tbl, cmd.wr_zero ? '0 : rem_r);
  assign ram_re    = cmd.rd_first || cmd.rd_next;
  assign ram_raddr = cmd.rd_first ? cnt_dec[AW-1:0] : (ptr_r - AW'(1));

  itrd_ram #(
    .WIDTH (SYM_W),
    .DEPTH (MAX_DIGITS)
  ) u_digits (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign out_valid        = out_valid_r;
  assign out_symbol       = out_symbol_r;
  assign out_last         = out_last_r;
  assign out_base_invalid = out_inv_r;

  a_gap_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_last) |=> !out_valid)
    else $error("result strobe right after the last symbol");

  a_invalid_alone: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_base_invalid) |-> out_last)
    else $error("invalid-base result is not a single final result");

  a_store_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.wr_digit |-> !stat.cnt_full)
    else $error("digit written past the end of the store");

endmodule
`default_nettype wire

[bench/itrd_checker.sv]
`timescale 1ns / 1ps
module itrd_checker
  import itrd_pkg::*;
(
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire logic                    start,
  input  wire logic                    busy,
  input  wire logic signed [MAG_W-1:0] in_number,
  input  wire logic                    out_valid,
  input  wire logic [SYM_W-1:0]        out_symbol,
  input  wire logic                    out_last,
  input  wire logic                    out_base_invalid,
  input  wire logic                    cfg_we,
  input  wire logic [CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [SYM_REG_W-1:0]    cfg_data,
  output int                           n_pending,
  output int                           n_errors
);

  // One emitted symbol transaction
  typedef struct packed {
    logic [SYM_W-1:0] symbol;
    logic             last;
    logic             base_invalid;
  } digit_txn_t;

  localparam int DIGIT_SLOTS = MAX_DIGITS_DEF;

  // Shadow copy of the configuration registers
  logic [RADIX_W-1:0]   radix_len;
  logic [SYM_REG_W-1:0] sym_bank [SYM_REGS];

  digit_txn_t expected_digits [$];
  int         error_tally = 0;

  // Symbol k lives in bank k/9 at bit 7*(k mod 9)
  function automatic logic [SYM_W-1:0] table_symbol(input int k);
    return sym_bank[k / 9][SYM_W * (k % 9) +: SYM_W];
  endfunction

  function automatic logic alnum_code(input logic [SYM_W-1:0] c);
    return (c >= CH_0 && c <= CH_9) || (c >= CH_LA && c <= CH_LZ) ||
           (c >= CH_UA && c <= CH_UZ);
  endfunction

  // Radix needs two or more symbols, all alphanumeric, no repeats
  function automatic logic radix_table_ok();
    int n;
    int i;
    int j;
    n = int'(radix_len);
    if (n < 2 || n > MAX_SYMBOLS) return 1'b0;
    for (i = 0; i < n; i++) begin
      if (!alnum_code(table_symbol(i))) return 1'b0;
      for (j = i + 1; j < n; j++) begin
        if (table_symbol(j) == table_symbol(i)) return 1'b0;
      end
    end
    return 1'b1;
  endfunction

  // Queue the symbols one number should produce, most significant first
  task automatic predict_digits(input logic [MAG_W-1:0] raw);
    logic [MAG_W-1:0] mag;
    logic [MAG_W-1:0] radix;
    logic [SYM_W-1:0] digits [DIGIT_SLOTS];
    logic             neg;
    int               count;
    int               k;
    if (!radix_table_ok()) begin
      expected_digits.push_back('{symbol: '0, last: 1'b1, base_invalid: 1'b1});
      return;
    end
    radix = MAG_W'(radix_len);
    neg   = raw[MAG_W-1];
    // unsigned magnitude, so the most negative value stays 2^31
    mag   = neg ? (MAG_W'(0) - raw) : raw;
    count = 0;
    if (mag == '0) begin
      digits[0] = table_symbol(0);
      count     = 1;
    end
    while (mag != '0 && count < DIGIT_SLOTS) begin
      digits[count] = table_symbol(int'(mag % radix));
      mag           = mag / radix;
      count++;
    end
    if (neg) expected_digits.push_back('{symbol: CH_MINUS, last: 1'b0, base_invalid: 1'b0});
    for (k = count - 1; k >= 0; k--) begin
      expected_digits.push_back('{symbol: digits[k], last: (k == 0), base_invalid: 1'b0});
    end
  endtask

  // Track config, predict on accepted numbers, compare each strobed symbol
  always @(posedge clk) begin
    digit_txn_t want;
    int         r;
    if (!rst_n) begin
      radix_len = '0;
      for (r = 0; r < SYM_REGS; r++) sym_bank[r] = '0;
      expected_digits.delete();
    end else begin
      if (cfg_we) begin
        if (cfg_index == REG_BASE_LENGTH) begin
          radix_len = cfg_data[RADIX_W-1:0];
        end else begin
          sym_bank[int'(cfg_index) - int'(REG_SYMBOLS_FIRST)] = cfg_data;
        end
      end
      if (start && !busy) predict_digits(in_number);
      if (out_valid) begin
        if (expected_digits.size() == 0) begin
          $error("unexpected symbol transaction: symbol 'h%0h, last %0b, base_invalid %0b",
                 out_symbol, out_last, out_base_invalid);
          error_tally++;
        end else begin
          want = expected_digits.pop_front();
          if (out_symbol !== want.symbol) begin
            $error("out_symbol: expected 'h%0h, actual 'h%0h", want.symbol, out_symbol);
            error_tally++;
          end
          if (out_last !== want.last) begin
            $error("out_last: expected %0b, actual %0b", want.last, out_last);
            error_tally++;
          end
          if (out_base_invalid !== want.base_invalid) begin
            $error("out_base_invalid: expected %0b, actual %0b",
                   want.base_invalid, out_base_invalid);
            error_tally++;
          end
        end
      end
    end
    n_pending <= expected_digits.size();
    n_errors  <= error_tally;
  end

endmodule

[bench/tb_integer_to_radix_digits.sv]
`timescale 1ns / 1ps
module tb_integer_to_radix_digits;
  import itrd_pkg::*;

  localparam int RANDOM_ITEMS = 450;
  localparam int CYCLE_LIMIT  = 3_000_000;
  localparam int ALNUM_COUNT  = 62;

  typedef enum {BASE_GOOD, BASE_DUP, BASE_BAD_CHAR, BASE_BAD_LEN} base_kind_t;

  logic                    clk;
  logic                    rst_n     = 1'b0;
  logic                    start     = 1'b0;
  logic                    busy;
  logic signed [MAG_W-1:0] in_number = '0;
  logic                    out_valid;
  logic [SYM_W-1:0]        out_symbol;
  logic                    out_last;
  logic                    out_base_invalid;
  logic                    cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0]    cfg_index = '0;
  logic [SYM_REG_W-1:0]    cfg_data  = '0;
  int                      n_pending;
  int                      n_errors;

  // Symbol table image and the pool of legal digit characters
  logic [SYM_W-1:0] sym_tab [MAX_SYMBOLS];
  logic [SYM_W-1:0] alnum_pool [ALNUM_COUNT];
  bit               idle_on = 1'b1;

  integer_to_radix_digits DUT (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_number        (in_number),
    .out_valid        (out_valid),
    .out_symbol       (out_symbol),
    .out_last         (out_last),
    .out_base_invalid (out_base_invalid),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data)
  );

  itrd_checker u_checker (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_number        (in_number),
    .out_valid        (out_valid),
    .out_symbol       (out_symbol),
    .out_last         (out_last),
    .out_base_invalid (out_base_invalid),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .n_pending        (n_pending),
    .n_errors         (n_errors)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  task automatic write_reg(input logic [CFG_IDX_W-1:0] index,
                           input logic [SYM_REG_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= index;
    cfg_data  <= data;
    @(posedge clk);
  endtask

  // Write length and all seven symbol banks; unused slots get junk
  task automatic program_base(input int len);
    logic [SYM_REG_W-1:0] word;
    int                   r;
    int                   j;
    for (j = len; j < MAX_SYMBOLS; j++) sym_tab[j] = SYM_W'($urandom);
    word              = SYM_REG_W'({$urandom, $urandom});
    word[RADIX_W-1:0] = RADIX_W'(len);
    write_reg(REG_BASE_LENGTH, word);
    for (r = 0; r < SYM_REGS; r++) begin
      for (j = 0; j < 9; j++) word[SYM_W*j +: SYM_W] = sym_tab[9*r + j];
      write_reg(CFG_IDX_W'(int'(REG_SYMBOLS_FIRST) + r), word);
    end
    cfg_we <= 1'b0;
  endtask

  task automatic load_string(input string s);
    int i;
    for (i = 0; i < s.len(); i++) sym_tab[i] = SYM_W'(s[i]);
  endtask

  // One number transaction, then a random gap (start low, junk on the bus)
  task automatic send_number(input logic [MAG_W-1:0] value);
    int gap;
    start     <= 1'b1;
    in_number <= value;
    do @(posedge clk); while (busy);
    gap = idle_on ? $urandom_range(0, 10) : 0;
    if (gap != 0) begin
      start     <= 1'b0;
      in_number <= $urandom;
      if ($urandom_range(0, 1) != 0) begin
        do @(posedge clk); while (busy);
      end
      repeat (gap) @(posedge clk);
    end
  endtask

  // Hold off until every predicted symbol has come and the block is idle
  task automatic settle();
    start <= 1'b0;
    do @(posedge clk); while (n_pending != 0 || busy);
    repeat (4) @(posedge clk);
  endtask

  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("timeout after %0d cycles", CYCLE_LIMIT);
    $display("*** FAILED ***");
    $finish;
  end

  initial begin
    int               i;
    int               j;
    int               len;
    int               items;
    int               sent;
    int               failures;
    base_kind_t       kind;
    logic [MAG_W-1:0] value;
    logic [SYM_W-1:0] swap;
    logic [MAG_W-1:0] extremes [5];
    string            near_alnum;

    extremes   = '{32'h8000_0000, 32'h7FFF_FFFF, 32'h0, 32'hFFFF_FFFF, 32'h1};
    near_alnum = "/:@[`{";
    for (i = 0; i < 10; i++) alnum_pool[i] = SYM_W'(int'(CH_0) + i);
    for (i = 0; i < 26; i++) begin
      alnum_pool[10 + i] = SYM_W'(int'(CH_LA) + i);
      alnum_pool[36 + i] = SYM_W'(int'(CH_UA) + i);
    end

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // Registers at reset: zero length means an invalid base
    send_number(32'h0);
    send_number(32'hFFFF_FFFF);
    settle();

    // Decimal: zero, signs, both extremes
    load_string("0123456789");
    program_base(10);
    send_number(32'h0);
    send_number(32'd7);
    send_number(-32'sd7);
    send_number(32'h7FFF_FFFF);
    send_number(32'h8000_0000);
    send_number(32'd1000000);
    settle();

    // Binary gives the longest digit strings
    load_string("01");
    program_base(2);
    send_number(32'h8000_0000);
    send_number(32'h7FFF_FFFF);
    send_number(32'd5);
    settle();

    load_string("0123456789ABCDEF");
    program_base(16);
    send_number(32'hFFFF_FFFF);
    settle();

    // Largest valid radix, every alphanumeric character once
    load_string("0123456789abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ");
    program_base(62);
    send_number(32'h8000_0000);
    send_number(32'd61);
    send_number(32'd62);
    settle();

    // Full 63-entry table cannot be all distinct alphanumerics
    sym_tab[62] = CH_0;
    program_base(63);
    send_number($urandom);
    settle();

    // Single symbol
    load_string("7");
    program_base(1);
    send_number(32'd3);
    settle();

    // Repeated symbol
    load_string("0120");
    program_base(4);
    send_number(32'd9);
    settle();

    // Characters just outside the alphanumeric ranges
    for (i = 0; i < near_alnum.len(); i++) begin
      load_string("0123456789");
      sym_tab[$urandom_range(0, 9)] = SYM_W'(near_alnum[i]);
      program_base(10);
      send_number($urandom);
      settle();
    end

    // Random bases, mostly valid, each followed by a burst of numbers
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      j    = $urandom_range(0, 9);
      kind = (j < 7) ? BASE_GOOD : base_kind_t'(j - 6);
      for (i = 0; i < ALNUM_COUNT; i++) sym_tab[i] = alnum_pool[i];
      for (i = ALNUM_COUNT - 1; i > 0; i--) begin
        j          = $urandom_range(0, i);
        swap       = sym_tab[i];
        sym_tab[i] = sym_tab[j];
        sym_tab[j] = swap;
      end
      case (kind)
        BASE_GOOD: begin
          len = ($urandom_range(0, 3) == 0) ? $urandom_range(2, 3) : $urandom_range(2, 62);
        end
        BASE_DUP: begin
          len        = $urandom_range(2, 62);
          i          = $urandom_range(0, len - 2);
          j          = $urandom_range(i + 1, len - 1);
          sym_tab[j] = sym_tab[i];
        end
        BASE_BAD_CHAR: begin
          len = $urandom_range(1, 62);
          i   = $urandom_range(0, len - 1);
          case ($urandom_range(0, 3))
            0:       sym_tab[i] = SYM_W'($urandom_range(0, 47));
            1:       sym_tab[i] = SYM_W'($urandom_range(58, 64));
            2:       sym_tab[i] = SYM_W'($urandom_range(91, 96));
            default: sym_tab[i] = SYM_W'($urandom_range(123, 127));
          endcase
        end
        default: begin
          case ($urandom_range(0, 2))
            0:       len = 0;
            1:       len = 1;
            default: len = 63;
          endcase
        end
      endcase
      program_base(len);
      items   = (kind == BASE_GOOD) ? $urandom_range(8, 20) : $urandom_range(1, 4);
      idle_on = ($urandom_range(0, 3) != 0);
      repeat (items) begin
        case ($urandom_range(0, 3))
          0:       value = $urandom;
          1:       value = $urandom_range(0, 200) - 100;
          2:       value = extremes[$urandom_range(0, 4)];
          default: begin
            value = $urandom >> $urandom_range(0, 31);
            if ($urandom_range(0, 1) != 0) value = -value;
          end
        endcase
        send_number(value);
        sent++;
      end
      settle();
    end

    repeat (40) @(posedge clk);
    failures = n_errors;
    if (n_pending != 0) begin
      $error("%0d expected symbol transactions never arrived", n_pending);
      failures++;
    end
    if (failures == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

[files.f]
design/itrd_pkg.sv
design/itrd_ram.sv
design/itrd_ctrl.sv
design/itrd_dp.sv
design/integer_to_radix_digits.sv
bench/itrd_checker.sv
bench/tb_integer_to_radix_digits.sv
